### src/swm_pkg.sv
// shared constants, types and control codes for the sliding window median filter
`default_nettype none
package swm_pkg;

    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_WIDTH = 32;
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int IDX_W        = $clog2(MAX_WINDOW);
    localparam int RES_W        = SAMPLE_WIDTH + 1;
    localparam int S_TDATA_W    = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int M_TDATA_W    = ((RES_W + 7) / 8) * 8;
    localparam int CFG_ADDR_W   = 3;
    localparam int CFG_DATA_W   = 32;
    localparam int WIN_W        = 7;

    localparam logic [WIN_W-1:0] WIN_RESET = WIN_W'(1);

    typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
    typedef logic signed [RES_W-1:0]        res_t;
    typedef logic [CNT_W-1:0]               cnt_t;
    typedef logic [IDX_W-1:0]               idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_PICK,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_REMOVE,
        CELL_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        sample_t  key;
        cnt_t     count;
    } cell_ctrl_t;

endpackage
`default_nettype wire

### src/swm_cell.sv
// one sorted cell: holds a window entry and shifts with its neighbors
`default_nettype none
module swm_cell (
    input  wire logic               aclk,
    input  wire swm_pkg::cell_ctrl_t ctrl,
    input  wire swm_pkg::idx_t      idx,
    input  wire swm_pkg::sample_t   up_val,
    input  wire swm_pkg::sample_t   dn_val,
    input  wire logic               dn_gt,
    output swm_pkg::sample_t        val,
    output logic                    gt
);

    swm_pkg::sample_t val_reg;
    swm_pkg::sample_t val_next;
    logic             valid;
    logic             ge;

    assign valid = {1'b0, idx} < ctrl.count;
    assign gt    = !valid || (val_reg > ctrl.key);
    assign ge    = valid && (val_reg >= ctrl.key);
    assign val   = val_reg;

    always_comb begin
        case (ctrl.op)
            swm_pkg::CELL_HOLD: begin
                val_next = val_reg;
            end
            swm_pkg::CELL_REMOVE: begin
                val_next = ge ? up_val : val_reg;
            end
            swm_pkg::CELL_INSERT: begin
                if (!gt) begin
                    val_next = val_reg;
                end else if (!dn_gt) begin
                    val_next = ctrl.key;
                end else begin
                    val_next = dn_val;
                end
            end
            default: begin
                val_next = val_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        val_reg <= val_next;
    end

endmodule
`default_nettype wire

### src/swm_chain.sv
// row of sorted cells with registered selection of the two middle entries
`default_nettype none
module swm_chain (
    input  wire logic                aclk,
    input  wire swm_pkg::cell_ctrl_t ctrl,
    input  wire swm_pkg::idx_t       lo_idx,
    input  wire swm_pkg::idx_t       hi_idx,
    input  wire logic                pick_en,
    output swm_pkg::sample_t         lo_val,
    output swm_pkg::sample_t         hi_val
);

    swm_pkg::sample_t vals [swm_pkg::MAX_WINDOW];
    logic             gts  [swm_pkg::MAX_WINDOW];
    swm_pkg::sample_t lo_reg;
    swm_pkg::sample_t lo_next;
    swm_pkg::sample_t hi_reg;
    swm_pkg::sample_t hi_next;

    for (genvar g = 0; g < swm_pkg::MAX_WINDOW; g++) begin : g_cell
        swm_pkg::sample_t up_v;
        swm_pkg::sample_t dn_v;
        logic             dn_g;

        if (g == swm_pkg::MAX_WINDOW - 1) begin : g_top
            assign up_v = '0;
        end else begin : g_mid_up
            assign up_v = vals[g+1];
        end

        if (g == 0) begin : g_bot
            assign dn_v = '0;
            assign dn_g = 1'b0;
        end else begin : g_mid_dn
            assign dn_v = vals[g-1];
            assign dn_g = gts[g-1];
        end

        swm_cell u_cell (
            .aclk   (aclk),
            .ctrl   (ctrl),
            .idx    (swm_pkg::IDX_W'(g)),
            .up_val (up_v),
            .dn_val (dn_v),
            .dn_gt  (dn_g),
            .val    (vals[g]),
            .gt     (gts[g])
        );
    end

    // and-or select of the two middle entries
    always_comb begin
        lo_next = '0;
        hi_next = '0;
        for (int i = 0; i < swm_pkg::MAX_WINDOW; i++) begin
            if (swm_pkg::IDX_W'(i) == lo_idx) begin
                lo_next = lo_next | vals[i];
            end
            if (swm_pkg::IDX_W'(i) == hi_idx) begin
                hi_next = hi_next | vals[i];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pick_en) begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign lo_val = lo_reg;
    assign hi_val = hi_reg;

endmodule
`default_nettype wire

### src/sliding_window_median.sv
// sliding window median filter: one sample per beat in, twice the window median out
// result path: remove, insert, pick, then emit registers the result beat once the output is free
// sample handling: one sample at a time; s_tready stays low through the remove and insert passes
//   through the sorted cell row, and through pick and emit for a sample that gives a result
// reset: synchronous active-low aresetn; window size returns to 1 and the window empties
// the arrival ring and cells hold no reset; entries are read only after being written
`default_nettype none
module sliding_window_median (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    // s_tdata: sample
    input  wire logic [swm_pkg::S_TDATA_W-1:0]         s_tdata,
    // s_tuser: start_req
    input  wire logic                                  s_tuser,
    input  wire logic                                  s_tvalid,
    output logic                                       s_tready,
    // m_tdata: median_doubled, zero padded
    output logic [swm_pkg::M_TDATA_W-1:0]              m_tdata,
    output logic                                       m_tvalid,
    input  wire logic                                  m_tready,
    input  wire logic                                  psel,
    input  wire logic                                  penable,
    input  wire logic                                  pwrite,
    input  wire logic [swm_pkg::CFG_ADDR_W-1:0]        paddr,
    input  wire logic [swm_pkg::CFG_DATA_W-1:0]        pwdata,
    output logic [swm_pkg::CFG_DATA_W-1:0]             prdata,
    output logic                                       pready
);

    swm_pkg::state_t  state_reg;
    swm_pkg::state_t  state_next;
    logic [swm_pkg::WIN_W-1:0] win_reg;
    logic [swm_pkg::WIN_W-1:0] win_next;
    swm_pkg::cnt_t    fill_reg;
    swm_pkg::cnt_t    fill_next;
    swm_pkg::idx_t    ptr_reg;
    swm_pkg::idx_t    ptr_next;
    logic             full_reg;
    logic             full_next;
    logic             emit_reg;
    logic             emit_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    swm_pkg::res_t    m_data_reg;
    swm_pkg::res_t    m_data_next;
    swm_pkg::sample_t x_reg;
    swm_pkg::sample_t old_reg;

    swm_pkg::sample_t arrival_mem [swm_pkg::MAX_WINDOW];

    swm_pkg::cnt_t    eff_w;
    swm_pkg::cnt_t    fill_e;
    swm_pkg::idx_t    ptr_e;
    swm_pkg::idx_t    ptr_inc;
    swm_pkg::idx_t    slot;
    swm_pkg::sample_t sample_in;
    logic             acc_full;
    logic             s_accept;
    logic             cfg_wr;
    logic             out_free;
    logic             load_out;
    logic             pick_en;
    swm_pkg::cell_ctrl_t ctrl;
    swm_pkg::idx_t    lo_idx;
    swm_pkg::idx_t    hi_idx;
    swm_pkg::sample_t lo_val;
    swm_pkg::sample_t hi_val;

    assign pready    = 1'b1;
    assign cfg_wr    = psel && penable && pwrite && pready && !paddr[2];
    assign prdata    = paddr[2] ? '0 : swm_pkg::CFG_DATA_W'(win_reg);
    assign sample_in = s_tdata[swm_pkg::SAMPLE_WIDTH-1:0];
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_valid_reg || m_tready;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {{(swm_pkg::M_TDATA_W - swm_pkg::RES_W){1'b0}}, m_data_reg};

    // window size clamped to 1..MAX_WINDOW
    always_comb begin
        if (win_reg == '0) begin
            eff_w = swm_pkg::CNT_W'(1);
        end else if (swm_pkg::CNT_W'(win_reg) > swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW)) begin
            eff_w = swm_pkg::CNT_W'(swm_pkg::MAX_WINDOW);
        end else begin
            eff_w = swm_pkg::CNT_W'(win_reg);
        end
    end

    assign fill_e   = s_tuser ? '0 : fill_reg;
    assign ptr_e    = s_tuser ? '0 : ptr_reg;
    assign acc_full = fill_e == eff_w;
    assign ptr_inc  = (swm_pkg::CNT_W'(ptr_e) + swm_pkg::CNT_W'(1) == eff_w) ?
                      '0 : ptr_e + swm_pkg::IDX_W'(1);
    assign slot     = acc_full ? ptr_e : fill_e[swm_pkg::IDX_W-1:0];

    assign lo_idx = swm_pkg::IDX_W'((eff_w - swm_pkg::CNT_W'(1)) >> 1);
    assign hi_idx = swm_pkg::IDX_W'(eff_w >> 1);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            swm_pkg::ST_IDLE: begin
                if (s_accept) begin
                    state_next = swm_pkg::ST_REMOVE;
                end
            end
            swm_pkg::ST_REMOVE: begin
                state_next = swm_pkg::ST_INSERT;
            end
            swm_pkg::ST_INSERT: begin
                state_next = emit_reg ? swm_pkg::ST_PICK : swm_pkg::ST_IDLE;
            end
            swm_pkg::ST_PICK: begin
                state_next = swm_pkg::ST_EMIT;
            end
            swm_pkg::ST_EMIT: begin
                if (out_free) begin
                    state_next = swm_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = swm_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_tready   = 1'b0;
        pick_en    = 1'b0;
        load_out   = 1'b0;
        ctrl.op    = swm_pkg::CELL_HOLD;
        ctrl.key   = x_reg;
        ctrl.count = fill_reg;
        case (state_reg)
            swm_pkg::ST_IDLE: begin
                s_tready = 1'b1;
            end
            swm_pkg::ST_REMOVE: begin
                ctrl.key = old_reg;
                ctrl.op  = full_reg ? swm_pkg::CELL_REMOVE : swm_pkg::CELL_HOLD;
            end
            swm_pkg::ST_INSERT: begin
                ctrl.op = swm_pkg::CELL_INSERT;
            end
            swm_pkg::ST_PICK: begin
                pick_en = 1'b1;
            end
            swm_pkg::ST_EMIT: begin
                load_out = out_free;
            end
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    // window bookkeeping
    always_comb begin
        win_next  = win_reg;
        fill_next = fill_reg;
        ptr_next  = ptr_reg;
        full_next = full_reg;
        emit_next = emit_reg;
        if (cfg_wr) begin
            win_next  = pwdata[swm_pkg::WIN_W-1:0];
            fill_next = '0;
            ptr_next  = '0;
        end else if (s_accept) begin
            fill_next = fill_e;
            ptr_next  = acc_full ? ptr_inc : ptr_e;
            full_next = acc_full;
            emit_next = acc_full || (fill_e + swm_pkg::CNT_W'(1) == eff_w);
        end else if (state_reg == swm_pkg::ST_REMOVE && full_reg) begin
            fill_next = fill_reg - swm_pkg::CNT_W'(1);
        end else if (state_reg == swm_pkg::ST_INSERT) begin
            fill_next = fill_reg + swm_pkg::CNT_W'(1);
        end
    end

    // output register
    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
            m_data_next  = swm_pkg::res_t'(lo_val) + swm_pkg::res_t'(hi_val);
        end else if (m_valid_reg && m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= swm_pkg::ST_IDLE;
            win_reg     <= swm_pkg::WIN_RESET;
            fill_reg    <= '0;
            ptr_reg     <= '0;
            full_reg    <= 1'b0;
            emit_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            win_reg     <= win_next;
            fill_reg    <= fill_next;
            ptr_reg     <= ptr_next;
            full_reg    <= full_next;
            emit_reg    <= emit_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (s_accept) begin
            x_reg <= sample_in;
        end
    end

    // arrival ring: oldest entry read before the new beat overwrites it
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            old_reg           <= arrival_mem[ptr_e];
            arrival_mem[slot] <= sample_in;
        end
    end

    swm_chain u_chain (
        .aclk    (aclk),
        .ctrl    (ctrl),
        .lo_idx  (lo_idx),
        .hi_idx  (hi_idx),
        .pick_en (pick_en),
        .lo_val  (lo_val),
        .hi_val  (hi_val)
    );

`ifndef SYNTH
    a_fill_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= eff_w)
        else $error("fill count above window size");

    a_ptr_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (ptr_reg == '0) || (swm_pkg::CNT_W'(ptr_reg) < eff_w))
        else $error("oldest pointer outside window");

    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> !s_tready)
        else $error("input taken again before item finished");

    a_result_from_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == swm_pkg::ST_EMIT))
        else $error("result raised outside emit state");
`endif

endmodule
`default_nettype wire

### test/sliding_window_median_test.sv
// self-checking testbench for the sliding window median filter
`timescale 1ns / 100ps

class median_tracker;
    swm_pkg::sample_t ring [swm_pkg::MAX_WINDOW];
    swm_pkg::sample_t ordered [swm_pkg::MAX_WINDOW];
    int unsigned held;
    int unsigned oldest;
    int unsigned window_reg;
    swm_pkg::res_t due_medians [$];
    int unsigned mismatches;

    function new();
        held = 0;
        oldest = 0;
        window_reg = 1;
        mismatches = 0;
    endfunction

    function void set_window(logic [swm_pkg::WIN_W-1:0] value);
        window_reg = 32'(value);
        held = 0;
        oldest = 0;
    endfunction

    function int unsigned pending();
        return due_medians.size();
    endfunction

    function void take_sample(swm_pkg::sample_t x, logic start);
        int unsigned w;
        int unsigned slot;
        int unsigned pos;
        int unsigned i;
        bit found;
        swm_pkg::sample_t gone;
        w = window_reg;
        if (w < 1) w = 1;
        if (w > swm_pkg::MAX_WINDOW) w = swm_pkg::MAX_WINDOW;
        if (start || held > w || oldest >= w) begin
            held = 0;
            oldest = 0;
        end
        if (held == w) begin
            slot = oldest;
            gone = ring[slot];
            pos = held - 1;
            found = 1'b0;
            for (i = 0; i < held; i++) begin
                if (!found && ordered[i] == gone) begin
                    pos = i;
                    found = 1'b1;
                end
            end
            for (i = pos; i + 1 < held; i++)
                ordered[i] = ordered[i + 1];
            held--;
            oldest = (oldest + 1) % w;
        end else begin
            slot = (oldest + held) % w;
        end
        ring[slot] = x;
        i = held;
        while (i > 0 && ordered[i - 1] > x) begin
            ordered[i] = ordered[i - 1];
            i--;
        end
        ordered[i] = x;
        held++;
        if (held == w)
            due_medians.insert(due_medians.size(),
                               swm_pkg::res_t'(ordered[(w - 1) / 2])
                               + swm_pkg::res_t'(ordered[w / 2]));
    endfunction

    function void check_median(logic [swm_pkg::M_TDATA_W-1:0] data);
        swm_pkg::res_t got;
        swm_pkg::res_t want;
        got = data[swm_pkg::RES_W-1:0];
        if (due_medians.size() == 0) begin
            $error("median_doubled: expected none, got %0d", got);
            mismatches++;
        end else begin
            want = due_medians.pop_front();
            if (got !== want) begin
                $error("median_doubled: expected %0d, got %0d", want, got);
                mismatches++;
            end
        end
    endfunction
endclass

module sliding_window_median_test;
    import swm_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_WINDOW_SIZE = CFG_ADDR_W'(0);
    localparam int unsigned STALL_LIMIT = 5000;
    localparam int unsigned LONG_HOLD = 80;
    localparam sample_t SAMPLE_MIN = sample_t'(32'h8000_0000);
    localparam sample_t SAMPLE_MAX = sample_t'(32'h7fff_ffff);

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic s_tuser = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr = '0;
    logic [CFG_DATA_W-1:0] pwdata = '0;
    logic [CFG_DATA_W-1:0] prdata;
    logic pready;

    bit idle_en = 1'b1;
    bit long_hold = 1'b0;
    median_tracker tracker;

    sliding_window_median dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .m_tdata(m_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) tracker.check_median(m_tdata);
            if (s_tvalid && s_tready) tracker.take_sample(s_tdata, s_tuser);
        end
    end

    // result side: random stalls, one long hold on request
    initial begin
        int unsigned stall;
        forever begin
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
                long_hold = 1'b0;
            end
            stall = idle_en ? $urandom_range(0, 4) : 0;
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid && !long_hold);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge aclk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet = 0;
            else quiet++;
        end
        $display("Mismatches found");
        $finish;
    end

    task automatic send_sample(input sample_t x, input logic start);
        int unsigned gap;
        gap = idle_en ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= x;
        s_tuser <= start;
        do @(posedge aclk); while (!s_tready);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (tracker.pending() != 0) @(posedge aclk);
        @(posedge aclk);
    endtask

    // window size writes only with the block idle, then read back
    task automatic write_window(input logic [WIN_W-1:0] value);
        drain();
        repeat (10) @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_WINDOW_SIZE;
        pwdata <= CFG_DATA_W'(value);
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        tracker.set_window(value);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (prdata !== CFG_DATA_W'(value)) begin
            $error("win_size: expected %0d, got %0d", value, prdata);
            tracker.mismatches++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic sample_t pick_sample();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return sample_t'($urandom);
            4, 5, 6: return sample_t'(int'($urandom_range(0, 6)) - 3);
            7: return SAMPLE_MIN + sample_t'($urandom_range(0, 2));
            8: return SAMPLE_MAX - sample_t'($urandom_range(0, 2));
            default: return sample_t'($urandom_range(0, 1) ? -1 : 0);
        endcase
    endfunction

    initial begin
        int unsigned widths [20];
        int unsigned total;
        int unsigned k;
        int unsigned w;
        int unsigned eff;
        int unsigned n;
        int unsigned i;
        bit pause_mid;

        widths = '{64, 127, 3, 1, 100, 2, 8, 4, 65, 5,
                   16, 7, 6, 33, 0, 12, 9, 63, 10, 11};
        tracker = new();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // window of one straight from reset
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(sample_t'(0), 1'b0);
        send_sample(sample_t'(-1), 1'b0);
        send_sample(SAMPLE_MIN, 1'b1);
        send_sample(SAMPLE_MAX, 1'b0);

        // size zero acts as one
        write_window(WIN_W'(0));
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);

        // even window, extreme sums, restart mid-stream
        write_window(WIN_W'(2));
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MAX, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(SAMPLE_MIN, 1'b0);
        send_sample(sample_t'(5), 1'b1);
        send_sample(sample_t'(-7), 1'b0);

        // equal samples on eviction
        write_window(WIN_W'(3));
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(2), 1'b0);
        send_sample(sample_t'(5), 1'b0);
        send_sample(sample_t'(5), 1'b0);

        total = 0;
        k = 0;
        while (total < 530) begin
            w = (k < 20) ? widths[k] : $urandom_range(1, 12);
            eff = (w < 1) ? 1 : ((w > MAX_WINDOW) ? MAX_WINDOW : w);
            n = eff + $urandom_range(6, 24);
            write_window(WIN_W'(w));
            idle_en = (k == 3) || ($urandom_range(0, 3) != 0);
            pause_mid = (k == 5);
            if (k == 3) begin
                n = 40;
                long_hold = 1'b1;
            end
            for (i = 0; i < n; i++) begin
                if (pause_mid && i == n / 2) drain();
                send_sample(pick_sample(), $urandom_range(0, 29) == 0);
            end
            total += n;
            k++;
        end

        drain();
        repeat (20) @(posedge aclk);
        if (tracker.mismatches == 0 && tracker.pending() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

### sliding_window_median.f
src/swm_pkg.sv
src/swm_cell.sv
src/swm_chain.sv
src/sliding_window_median.sv
test/sliding_window_median_test.sv
